// ----- src/tof_window_max_hit_count_top_assert.svh -----
// assertion macros for the tof window block
// both sample on clk and are disabled while rst_n is low
`ifndef TOF_WINDOW_MAX_HIT_COUNT_TOP_ASSERT_SVH
`define TOF_WINDOW_MAX_HIT_COUNT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TOF_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define TOF_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define TOF_ASSERT_IMP(label, cond, prop, msg)
`define TOF_ASSERT_NXT(label, cond, prop, msg)
`endif
`endif

// ----- src/tofwmh_pkg.sv -----
`default_nettype none
package tofwmh_pkg;

    localparam int MAX_HITS    = 2048;
    localparam int CNT_W       = 12;
    localparam int HIT_AW      = 11;
    localparam int NUM_SENSORS = 16384;
    localparam int POS_AW      = 14;
    localparam int IDX_W       = 15;
    localparam int CRD_W       = 20;
    localparam int TIME_W      = 24;
    localparam int CT_W        = 26;
    localparam int WIN_W       = 16;
    localparam int DIF_W       = 21;
    localparam int SUM_W       = 42;
    localparam int ROOT_W      = 21;
    localparam int REM_W       = 25;
    localparam int NUM_W       = 25;
    localparam int PROD_W      = 50;
    localparam int QUO_W       = 17;
    localparam int DIV_SHIFT   = 33;
    localparam int SQRT_STEPS  = 21;

    localparam logic [WIN_W-1:0] WIN_RESET   = 16'd800;
    // floor(2^33 / 259), error stays below one for 25 bit numerators
    localparam logic [NUM_W-1:0] RECIP_M     = 25'd33165770;
    localparam logic [NUM_W-1:0] SPEED_NUM_C = 25'd259;
    localparam logic [NUM_W-1:0] SPEED_DEN_C = 25'd12;
    localparam logic [NUM_W-1:0] ROUND_ADD   = 25'd129;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_VERTEX = 2'd1,
        OP_HIT    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic capture;
        logic dispatch;
        logic hit;
        logic diff;
        logic mul;
        logic sqrt;
        logic divm;
        logic divf;
        logic ins_rd;
        logic ins_cmp;
        logic win_init;
        logic wi_rd;
        logic wi_cap;
        logic wj_rd;
        logic wj_cmp;
        logic wupd;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic op_hit;
        logic hit_ok;
        logic last;
        logic mul_last;
        logic sqrt_last;
        logic ins_zero;
        logic ins_shift;
        logic cnt_zero;
        logic j_lt_n;
        logic j_in;
        logic i_last;
    } stat_t;

endpackage
`default_nettype wire

// ----- src/tof_window_max_hit_count_top.sv -----
`default_nettype none
// time of flight corrected coincidence counter. load sensor positions with
// operation load, open an event with a vertex item, then send hit items; the
// hit flagged last_hit gives one result on result_valid for a single cycle,
// which the receiver cannot stall. an item is taken when start is high and
// busy low. a stored hit first gets its distance (three squares, one root
// bit per cycle, a reciprocal divide), then moves past larger stored
// times in the sort buffer. the window scan on the last hit reads the same
// buffer: for each start position it reads that time, then steps the far
// end on while its time stays within the window.
// window_width is written on the cfg channel, which is always ready; write
// it only while the block is idle
module tof_window_max_hit_count_top
    import tofwmh_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic        [1:0]        operation,
    input  wire logic        [IDX_W-1:0]  sensor_index,
    input  wire logic signed [CRD_W-1:0]  coord_x,
    input  wire logic signed [CRD_W-1:0]  coord_y,
    input  wire logic signed [CRD_W-1:0]  coord_z,
    input  wire logic signed [TIME_W-1:0] hit_time,
    input  wire logic                     last_hit,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic        [WIN_W-1:0]  cfg_data,
    output logic                          result_valid,
    output logic             [CNT_W-1:0]  max_in_window,
    output logic             [CNT_W-1:0]  total_hits,
    output logic                          overflow
);

    // controller to datapath commands and status back
    cmd_t  cmd;
    stat_t stat;

    // the width register never blocks
    assign cfg_ready = 1'b1;

    tofwmh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // position table, sort buffer, root and divide units, window scan
    tofwmh_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .sensor_index  (sensor_index),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .hit_time      (hit_time),
        .last_hit      (last_hit),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .max_in_window (max_in_window),
        .total_hits    (total_hits),
        .overflow      (overflow)
    );

endmodule
`default_nettype wire

// ----- src/tofwmh_ctrl.sv -----
`default_nettype none
module tofwmh_ctrl
    import tofwmh_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire stat_t stat,
    output logic       busy,
    output cmd_t       cmd
);

    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_DISP     = 17'b00000000000000010,
        S_HIT      = 17'b00000000000000100,
        S_DIFF     = 17'b00000000000001000,
        S_MUL      = 17'b00000000000010000,
        S_SQRT     = 17'b00000000000100000,
        S_DIVM     = 17'b00000000001000000,
        S_DIVF     = 17'b00000000010000000,
        S_INS_RD   = 17'b00000000100000000,
        S_INS_CMP  = 17'b00000001000000000,
        S_WIN_INIT = 17'b00000010000000000,
        S_WI_RD    = 17'b00000100000000000,
        S_WI_CAP   = 17'b00001000000000000,
        S_WJ_RD    = 17'b00010000000000000,
        S_WJ_CMP   = 17'b00100000000000000,
        S_WUPD     = 17'b01000000000000000,
        S_EMIT     = 17'b10000000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (start) state_next = S_DISP;
            S_DISP:     state_next = stat.op_hit ? S_HIT : S_IDLE;
            S_HIT:
            begin
                if (stat.hit_ok)
                    state_next = S_DIFF;
                else
                    state_next = stat.last ? S_WIN_INIT : S_IDLE;
            end
            S_DIFF:     state_next = S_MUL;
            S_MUL:      if (stat.mul_last) state_next = S_SQRT;
            S_SQRT:     if (stat.sqrt_last) state_next = S_DIVM;
            S_DIVM:     state_next = S_DIVF;
            S_DIVF:     state_next = S_INS_RD;
            S_INS_RD:
            begin
                if (stat.ins_zero)
                    state_next = stat.last ? S_WIN_INIT : S_IDLE;
                else
                    state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (stat.ins_shift)
                    state_next = S_INS_RD;
                else
                    state_next = stat.last ? S_WIN_INIT : S_IDLE;
            end
            S_WIN_INIT: state_next = stat.cnt_zero ? S_EMIT : S_WI_RD;
            S_WI_RD:    state_next = S_WI_CAP;
            S_WI_CAP:   state_next = S_WJ_RD;
            S_WJ_RD:    state_next = stat.j_lt_n ? S_WJ_CMP : S_WUPD;
            S_WJ_CMP:   state_next = stat.j_in ? S_WJ_RD : S_WUPD;
            S_WUPD:     state_next = stat.i_last ? S_EMIT : S_WI_RD;
            S_EMIT:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign cmd.capture  = start && (state_reg == S_IDLE);
    assign cmd.dispatch = (state_reg == S_DISP);
    assign cmd.hit      = (state_reg == S_HIT);
    assign cmd.diff     = (state_reg == S_DIFF);
    assign cmd.mul      = (state_reg == S_MUL);
    assign cmd.sqrt     = (state_reg == S_SQRT);
    assign cmd.divm     = (state_reg == S_DIVM);
    assign cmd.divf     = (state_reg == S_DIVF);
    assign cmd.ins_rd   = (state_reg == S_INS_RD);
    assign cmd.ins_cmp  = (state_reg == S_INS_CMP);
    assign cmd.win_init = (state_reg == S_WIN_INIT);
    assign cmd.wi_rd    = (state_reg == S_WI_RD);
    assign cmd.wi_cap   = (state_reg == S_WI_CAP);
    assign cmd.wj_rd    = (state_reg == S_WJ_RD);
    assign cmd.wj_cmp   = (state_reg == S_WJ_CMP);
    assign cmd.wupd     = (state_reg == S_WUPD);
    assign cmd.emit     = (state_reg == S_EMIT);

endmodule
`default_nettype wire

// ----- src/tofwmh_dp.sv -----
`default_nettype none
`include "tof_window_max_hit_count_top_assert.svh"
module tofwmh_dp
    import tofwmh_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    output stat_t                         stat,
    input  wire logic        [1:0]        operation,
    input  wire logic        [IDX_W-1:0]  sensor_index,
    input  wire logic signed [CRD_W-1:0]  coord_x,
    input  wire logic signed [CRD_W-1:0]  coord_y,
    input  wire logic signed [CRD_W-1:0]  coord_z,
    input  wire logic signed [TIME_W-1:0] hit_time,
    input  wire logic                     last_hit,
    input  wire logic                     cfg_valid,
    input  wire logic        [WIN_W-1:0]  cfg_data,
    output logic                          result_valid,
    output logic             [CNT_W-1:0]  max_in_window,
    output logic             [CNT_W-1:0]  total_hits,
    output logic                          overflow
);

    // captured item
    logic        [1:0]        op_reg;
    logic        [IDX_W-1:0]  idx_reg;
    logic signed [CRD_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic signed [TIME_W-1:0] ht_reg;
    logic                     last_reg;

    // event state
    logic signed [CRD_W-1:0]  vx_reg, vy_reg, vz_reg;
    logic        [CNT_W-1:0]  cnt_reg;
    logic                     ovf_reg;
    logic        [WIN_W-1:0]  win_reg;

    // flight time path
    logic [DIF_W-1:0]  ax_reg, ay_reg, az_reg;
    logic [1:0]        k_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        scnt_reg;
    logic [NUM_W-1:0]  n_reg;
    logic [PROD_W-1:0] prod_reg;
    logic signed [CT_W-1:0] tc_reg;

    // sort and window scan
    logic [CNT_W-1:0]  p_reg, i_reg, j_reg, best_reg;
    logic signed [CT_W-1:0] ti_reg;

    // result
    logic              rv_reg;
    logic [CNT_W-1:0]  max_reg, tot_reg;
    logic              ovo_reg;

    // memories
    logic [3*CRD_W-1:0]     pos_mem [NUM_SENSORS];
    logic [3*CRD_W-1:0]     pos_q;
    logic signed [CT_W-1:0] t_mem [MAX_HITS];
    logic signed [CT_W-1:0] tq;

    logic [IDX_W-1:0]  idx_m1;
    logic [POS_AW-1:0] pos_addr;
    logic              idx_ok;
    logic              full;

    logic signed [CRD_W-1:0] px, py, pz;
    logic signed [DIF_W-1:0] dx, dy, dz;
    logic [DIF_W-1:0]  a_sel;
    logic [REM_W-1:0]  rem_sh, trial;
    logic [NUM_W-1:0]  n_calc, r_calc;
    logic [QUO_W-1:0]  q0, q;
    logic [CNT_W-1:0]  p_m1, span;
    logic signed [CT_W:0] tdiff;

    logic              t_we;
    logic [HIT_AW-1:0] t_wa, t_ra;
    logic signed [CT_W-1:0] t_wd;

    assign idx_m1   = idx_reg - IDX_W'(1);
    assign pos_addr = idx_m1[POS_AW-1:0];
    assign idx_ok   = (idx_reg != '0) && (idx_reg <= IDX_W'(NUM_SENSORS));
    assign full     = (cnt_reg == CNT_W'(MAX_HITS));

    assign px = pos_q[3*CRD_W-1:2*CRD_W];
    assign py = pos_q[2*CRD_W-1:CRD_W];
    assign pz = pos_q[CRD_W-1:0];
    assign dx = DIF_W'(vx_reg) - DIF_W'(px);
    assign dy = DIF_W'(vy_reg) - DIF_W'(py);
    assign dz = DIF_W'(vz_reg) - DIF_W'(pz);

    always_comb
    begin
        case (k_reg)
            2'd0:    a_sel = ax_reg;
            2'd1:    a_sel = ay_reg;
            default: a_sel = az_reg;
        endcase
    end

    // one root bit per step
    assign rem_sh = {rem_reg[REM_W-3:0], sum_reg[SUM_W-1:SUM_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    // rounded divide by 259/12 via reciprocal
    assign n_calc = NUM_W'(root_reg) * SPEED_DEN_C + ROUND_ADD;
    assign q0     = prod_reg[DIV_SHIFT +: QUO_W];
    assign r_calc = n_reg - NUM_W'(q0) * SPEED_NUM_C;
    assign q      = (r_calc >= SPEED_NUM_C) ? q0 + QUO_W'(1) : q0;

    assign p_m1  = p_reg - CNT_W'(1);
    assign span  = j_reg - i_reg;
    assign tdiff = (CT_W+1)'(tq) - (CT_W+1)'(ti_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.dispatch && (op_reg == OP_LOAD) && idx_ok)
            pos_mem[pos_addr] <= {cx_reg, cy_reg, cz_reg};
        pos_q <= pos_mem[pos_addr];
    end

    always_comb
    begin
        t_we = 1'b0;
        t_wa = p_reg[HIT_AW-1:0];
        t_wd = tc_reg;
        if (cmd.ins_rd && (p_reg == '0))
            t_we = 1'b1;
        if (cmd.ins_cmp)
        begin
            t_we = 1'b1;
            if (tq > tc_reg)
                t_wd = tq;
        end
        if (cmd.ins_rd)
            t_ra = p_m1[HIT_AW-1:0];
        else if (cmd.wi_rd)
            t_ra = i_reg[HIT_AW-1:0];
        else if (cmd.wj_rd)
            t_ra = j_reg[HIT_AW-1:0];
        else
            t_ra = '0;
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
            t_mem[t_wa] <= t_wd;
        tq <= t_mem[t_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            idx_reg  <= sensor_index;
            cx_reg   <= coord_x;
            cy_reg   <= coord_y;
            cz_reg   <= coord_z;
            ht_reg   <= hit_time;
            last_reg <= last_hit;
        end
        if (cmd.diff)
        begin
            ax_reg   <= dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
            ay_reg   <= dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);
            az_reg   <= dz[DIF_W-1] ? DIF_W'(-dz) : DIF_W'(dz);
            k_reg    <= '0;
            sum_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            scnt_reg <= '0;
        end
        if (cmd.mul)
        begin
            sum_reg <= sum_reg + SUM_W'(a_sel * a_sel);
            k_reg   <= k_reg + 2'd1;
        end
        if (cmd.sqrt)
        begin
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
            sum_reg  <= {sum_reg[SUM_W-3:0], 2'b00};
            scnt_reg <= scnt_reg + 5'd1;
        end
        if (cmd.divm)
        begin
            n_reg    <= n_calc;
            prod_reg <= PROD_W'(n_calc) * PROD_W'(RECIP_M);
        end
        if (cmd.divf)
        begin
            tc_reg <= CT_W'(ht_reg) - CT_W'(q);
            p_reg  <= cnt_reg;
        end
        if (cmd.ins_cmp && (tq > tc_reg))
            p_reg <= p_m1;
        if (cmd.win_init)
        begin
            i_reg    <= '0;
            j_reg    <= '0;
            best_reg <= '0;
        end
        if (cmd.wi_cap)
        begin
            ti_reg <= tq;
            if (j_reg < i_reg)
                j_reg <= i_reg;
        end
        if (cmd.wj_cmp && stat.j_in)
            j_reg <= j_reg + CNT_W'(1);
        if (cmd.wupd)
        begin
            if (span > best_reg)
                best_reg <= span;
            i_reg <= i_reg + CNT_W'(1);
        end
        if (cmd.emit)
        begin
            max_reg <= best_reg;
            tot_reg <= cnt_reg;
            ovo_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg  <= '0;
            vy_reg  <= '0;
            vz_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            win_reg <= WIN_RESET;
            rv_reg  <= 1'b0;
        end
        else
        begin
            rv_reg <= cmd.emit;
            if (cfg_valid)
                win_reg <= cfg_data;
            if (cmd.dispatch && (op_reg == OP_VERTEX))
            begin
                vx_reg  <= cx_reg;
                vy_reg  <= cy_reg;
                vz_reg  <= cz_reg;
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (cmd.hit && idx_ok && full)
                ovf_reg <= 1'b1;
            if ((cmd.ins_rd && (p_reg == '0)) || (cmd.ins_cmp && !(tq > tc_reg)))
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.emit)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    assign stat.op_hit    = (op_reg == OP_HIT);
    assign stat.hit_ok    = idx_ok && !full;
    assign stat.last      = last_reg;
    assign stat.mul_last  = (k_reg == 2'd2);
    assign stat.sqrt_last = (scnt_reg == 5'(SQRT_STEPS - 1));
    assign stat.ins_zero  = (p_reg == '0);
    assign stat.ins_shift = (tq > tc_reg);
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.j_lt_n    = (j_reg < cnt_reg);
    assign stat.j_in      = (tdiff <= $signed({1'b0, {(CT_W-WIN_W){1'b0}}, win_reg}));
    assign stat.i_last    = ((i_reg + CNT_W'(1)) == cnt_reg);

    assign result_valid  = rv_reg;
    assign max_in_window = max_reg;
    assign total_hits    = tot_reg;
    assign overflow      = ovo_reg;

    `TOF_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_reg <= CNT_W'(MAX_HITS), "hit count above capacity")
    `TOF_ASSERT_IMP(a_emit_clr, rv_reg, (cnt_reg == '0) && !ovf_reg, "event not cleared")
    `TOF_ASSERT_NXT(a_ins_step, cmd.ins_cmp && stat.ins_shift, p_reg == $past(p_m1), "bad shift")
    `TOF_ASSERT_NXT(a_win_step, cmd.wj_cmp && stat.j_in, j_reg == $past(j_reg) + CNT_W'(1), "bad j")

endmodule
`default_nettype wire
